// ===== rtl/upt_pkg.sv =====
// shared types and constants for the url component tokenizer
package upt_pkg;

  // parser states
  localparam logic [3:0] ST_SCHEME   = 4'd0;
  localparam logic [3:0] ST_SLASH1   = 4'd1;
  localparam logic [3:0] ST_SLASH2   = 4'd2;
  localparam logic [3:0] ST_NAME     = 4'd3;
  localparam logic [3:0] ST_PASSWORD = 4'd4;
  localparam logic [3:0] ST_HOST     = 4'd5;
  localparam logic [3:0] ST_DIGITS   = 4'd6;
  localparam logic [3:0] ST_PORT     = 4'd7;
  localparam logic [3:0] ST_PATH     = 4'd8;
  localparam logic [3:0] ST_QUERY    = 4'd9;
  localparam logic [3:0] ST_FRAGMENT = 4'd10;
  localparam logic [3:0] ST_FAILED   = 4'd11;

  // byte kinds
  localparam logic [3:0] K_DELIM  = 4'd0;
  localparam logic [3:0] K_SCHEME = 4'd1;
  localparam logic [3:0] K_NAMEP  = 4'd2;
  localparam logic [3:0] K_USER   = 4'd3;
  localparam logic [3:0] K_PASS   = 4'd4;
  localparam logic [3:0] K_HOST   = 4'd5;
  localparam logic [3:0] K_DIGITP = 4'd6;
  localparam logic [3:0] K_PORT   = 4'd7;
  localparam logic [3:0] K_PATH   = 4'd8;
  localparam logic [3:0] K_QUERY  = 4'd9;
  localparam logic [3:0] K_FRAG   = 4'd10;

  // run resolutions
  localparam logic [1:0] NAME_NONE = 2'd0;
  localparam logic [1:0] NAME_HOST = 2'd1;
  localparam logic [1:0] NAME_USER = 2'd2;
  localparam logic [1:0] DIG_NONE  = 2'd0;
  localparam logic [1:0] DIG_PORT  = 2'd1;
  localparam logic [1:0] DIG_PASS  = 2'd2;

  // error codes
  localparam logic [3:0] ERR_NONE           = 4'd0;
  localparam logic [3:0] ERR_PENDING_DIGITS = 4'd9;

  localparam logic [15:0] PORT_MAX = 16'hFFFF;

  // characters of interest
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_AT      = 8'h40;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_QMARK   = 8'h3F;
  localparam logic [7:0] CH_LBRACK  = 8'h5B;
  localparam logic [7:0] CH_UNDER   = 8'h5F;
  localparam logic [7:0] CH_TILDE   = 8'h7E;

  localparam int unsigned OUT_TDATA_W = 40;

  typedef struct packed {
    logic digit;
    logic alnum;
    logic unres;
    logic plus;
    logic minus;
    logic dot;
    logic colon;
    logic slash;
    logic at;
    logic percent;
    logic hash;
    logic qmark;
    logic lbrack;
  } upt_cls_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [1:0]  name_is;
    logic [1:0]  digit_is;
    logic [15:0] port;
    logic [3:0]  err;
  } upt_res_t;

endpackage

// ===== rtl/upt_char_class.sv =====
// character classifier for one url byte
module upt_char_class
  import upt_pkg::*;
(
  input  logic [7:0] ch,
  output upt_cls_t   cls
);

  logic is_dig;
  logic is_alp;

  always_comb begin
    is_dig = ch inside {[8'h30:8'h39]};
    is_alp = (ch inside {[8'h61:8'h7A]}) || (ch inside {[8'h41:8'h5A]});
    cls.digit   = is_dig;
    cls.alnum   = is_dig || is_alp;
    cls.unres   = is_dig || is_alp || ch == CH_MINUS || ch == CH_DOT ||
                  ch == CH_UNDER || ch == CH_TILDE;
    cls.plus    = ch == CH_PLUS;
    cls.minus   = ch == CH_MINUS;
    cls.dot     = ch == CH_DOT;
    cls.colon   = ch == CH_COLON;
    cls.slash   = ch == CH_SLASH;
    cls.at      = ch == CH_AT;
    cls.percent = ch == CH_PERCENT;
    cls.hash    = ch == CH_HASH;
    cls.qmark   = ch == CH_QMARK;
    cls.lbrack  = ch == CH_LBRACK;
  end

endmodule

// ===== rtl/upt_parse_core.sv =====
// parser state registers and per-byte next-state logic
module upt_parse_core
  import upt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] ch,
  input  logic       last,
  input  upt_cls_t   cls,
  output upt_res_t   res
);

  logic [3:0]  state_r, state_nxt;
  logic [3:0]  err_r, err_nxt;
  logic [15:0] port_r, port_nxt;
  logic        name_ne_r, name_ne_nxt;
  logic        dig_ne_r, dig_ne_nxt;
  logic        host_ne_r, host_ne_nxt;

  logic [19:0] port_sum;
  logic [15:0] port_add;
  logic        bad;
  logic [3:0]  kind;
  logic [1:0]  name_is;
  logic [1:0]  digit_is;

  // acc*10 + digit, saturating
  always_comb begin
    port_sum = {port_r, 3'b000} + {3'b000, port_r, 1'b0} + {16'd0, ch[3:0] - 4'h0};
    port_add = (port_sum[19:16] != 4'd0) ? PORT_MAX : port_sum[15:0];
  end

  always_comb begin
    state_nxt   = state_r;
    err_nxt     = err_r;
    port_nxt    = port_r;
    name_ne_nxt = name_ne_r;
    dig_ne_nxt  = dig_ne_r;
    host_ne_nxt = host_ne_r;
    kind        = K_DELIM;
    name_is     = NAME_NONE;
    digit_is    = DIG_NONE;
    bad         = 1'b0;

    case (state_r)
      ST_SCHEME: begin
        if (cls.alnum || cls.plus || cls.minus || cls.dot) kind = K_SCHEME;
        else if (cls.colon) state_nxt = ST_SLASH1;
        else bad = 1'b1;
      end
      ST_SLASH1: begin
        if (cls.slash) state_nxt = ST_SLASH2;
        else if (cls.alnum) begin
          kind = K_NAMEP;
          name_ne_nxt = 1'b1;
          state_nxt = ST_NAME;
        end else bad = 1'b1;
      end
      ST_SLASH2: begin
        if (cls.slash) state_nxt = ST_NAME;
        else bad = 1'b1;
      end
      ST_NAME: begin
        if (cls.unres || cls.percent) begin
          kind = K_NAMEP;
          name_ne_nxt = 1'b1;
        end else if (cls.colon) state_nxt = ST_DIGITS;
        else if (cls.at) begin
          name_is = NAME_USER;
          name_ne_nxt = 1'b0;
          host_ne_nxt = 1'b0;
          state_nxt = ST_HOST;
        end else if (cls.slash) begin
          name_is = NAME_HOST;
          name_ne_nxt = 1'b0;
          state_nxt = ST_PATH;
        end else bad = 1'b1;
      end
      ST_PASSWORD: begin
        if (cls.alnum || cls.percent) kind = K_PASS;
        else if (cls.at) begin
          host_ne_nxt = 1'b0;
          state_nxt = ST_HOST;
        end else bad = 1'b1;
      end
      ST_HOST: begin
        // ipv6 literal is not supported
        if (cls.lbrack && !host_ne_r) bad = 1'b1;
        else if (cls.unres || cls.percent) begin
          kind = K_HOST;
          host_ne_nxt = 1'b1;
        end else if (cls.colon) state_nxt = ST_PORT;
        else if (cls.slash) state_nxt = ST_PATH;
        else bad = 1'b1;
      end
      ST_DIGITS: begin
        if (cls.digit) begin
          kind = K_DIGITP;
          dig_ne_nxt = 1'b1;
          port_nxt = port_add;
        end else if (cls.slash) begin
          name_is = NAME_HOST;
          digit_is = DIG_PORT;
          name_ne_nxt = 1'b0;
          dig_ne_nxt = 1'b0;
          state_nxt = ST_PATH;
        end else if (cls.alnum || cls.percent) begin
          kind = K_PASS;
          name_is = NAME_USER;
          digit_is = DIG_PASS;
          name_ne_nxt = 1'b0;
          dig_ne_nxt = 1'b0;
          port_nxt = 16'd0;
          state_nxt = ST_PASSWORD;
        end else bad = 1'b1;
      end
      ST_PORT: begin
        if (cls.digit) begin
          kind = K_PORT;
          port_nxt = port_add;
        end else if (cls.slash) state_nxt = ST_PATH;
        else bad = 1'b1;
      end
      ST_PATH: begin
        if (cls.hash) state_nxt = ST_FRAGMENT;
        else if (cls.qmark) state_nxt = ST_QUERY;
        else kind = K_PATH;
      end
      ST_QUERY: begin
        if (cls.hash) state_nxt = ST_FRAGMENT;
        else if (!cls.qmark) kind = K_QUERY;
      end
      ST_FRAGMENT: begin
        kind = K_FRAG;
      end
      default: begin
        state_nxt = ST_FAILED;
      end
    endcase

    if (bad) begin
      err_nxt = state_r + 4'd1;
      state_nxt = ST_FAILED;
      kind = K_DELIM;
    end

    // end of url settles what is still open
    if (last && err_nxt == ERR_NONE) begin
      if (state_nxt == ST_DIGITS && dig_ne_nxt) err_nxt = ERR_PENDING_DIGITS;
      else if ((state_nxt == ST_NAME || state_nxt == ST_DIGITS) && name_ne_nxt &&
               name_is == NAME_NONE)
        name_is = NAME_HOST;
    end

    res.kind     = kind;
    res.name_is  = name_is;
    res.digit_is = digit_is;
    res.port     = port_nxt;
    res.err      = err_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && last)) begin
      state_r   <= ST_SCHEME;
      err_r     <= ERR_NONE;
      port_r    <= 16'd0;
      name_ne_r <= 1'b0;
      dig_ne_r  <= 1'b0;
      host_ne_r <= 1'b0;
    end else if (step) begin
      state_r   <= state_nxt;
      err_r     <= err_nxt;
      port_r    <= port_nxt;
      name_ne_r <= name_ne_nxt;
      dig_ne_r  <= dig_ne_nxt;
      host_ne_r <= host_ne_nxt;
    end
  end

  a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
    step && last |=> state_r == ST_SCHEME && err_r == ERR_NONE && port_r == 16'd0)
    else $error("parser not back to start after final byte");

  a_err_failed: assert property (@(posedge clk) disable iff (!rst_n)
    err_r != ERR_NONE |-> state_r == ST_FAILED)
    else $error("stored error outside failed state");

  a_name_run: assert property (@(posedge clk) disable iff (!rst_n)
    name_ne_r |-> state_r == ST_NAME || state_r == ST_DIGITS || state_r == ST_FAILED)
    else $error("open name run in wrong state");

  a_digit_run: assert property (@(posedge clk) disable iff (!rst_n)
    dig_ne_r |-> state_r == ST_DIGITS || state_r == ST_FAILED)
    else $error("open digit run in wrong state");

endmodule

// ===== rtl/url_component_tokenizer.sv =====
// url component tokenizer top level: input register, parser, result register
// a request is held in the input register until the result register frees up, then its result is registered there
// throughput: one byte per cycle while out_tready keeps draining the result register, bounded by the parser state loop
// while the result waits on out_tready the input register takes one more request
// reset: synchronous active-low rst_n empties both registers and puts the parser
// in the scheme state with no error, zero port and no open runs
module url_component_tokenizer
  import upt_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // in_tdata: [7:0] byte_in
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,
  input  logic                   in_tlast,   // end_of_url
  // out_tdata: [7:0] char_out, [11:8] char_kind, [13:12] name_run_is,
  // [15:14] digit_run_is, [31:16] port_value, [35:32] error_code, [39:36] zero
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast   // done_res
);

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;

  // result register
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  upt_res_t   out_res_r;
  logic       out_last_r;

  logic       s2_ready;
  logic       step;
  logic       in_fire;
  upt_cls_t   cls;
  upt_res_t   res;

  // result register frees up when empty or being drained
  assign s2_ready  = !out_valid_r || out_tready;
  // parser advances when a byte sits in the input register and can move on
  assign step      = s1_valid_r && s2_ready;
  assign in_tready = !s1_valid_r || s2_ready;
  assign in_fire   = in_tvalid && in_tready;

  upt_char_class u_cls (
    .ch  (s1_byte_r),
    .cls (cls)
  );

  upt_parse_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .ch    (s1_byte_r),
    .last  (s1_last_r),
    .cls   (cls),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (step) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_byte_r <= s1_byte_r;
      out_res_r  <= res;
      out_last_r <= s1_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {4'd0, out_res_r.err, out_res_r.port, out_res_r.digit_is,
                       out_res_r.name_is, out_res_r.kind, out_byte_r};

endmodule
